### rtl/core/dsc_pkg.sv
// ----------------------------------------------------------------------------
// Decimal score counter package
// Shared widths, item types and a helper function for the score counter.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int unsigned Positions     = 8;
  localparam int unsigned DefaultDigits = 8;
  localparam int unsigned ValueW        = 28;
  localparam int unsigned ScoreW        = 27;
  localparam int unsigned DigitW        = 4;
  localparam int unsigned StepsPerStage = 7;
  localparam int unsigned ConvStages    = (ScoreW + StepsPerStage - 1) / StepsPerStage;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QueuePtrW     = 1;
  localparam int unsigned QueueCntW     = 2;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SET = 1'b1
  } op_e;

  typedef struct packed {
    op_e                      op;
    logic signed [ValueW-1:0] value;
  } item_t;

  // Largest score shown on the given number of digits: 10^digits - 1
  function automatic logic [ScoreW-1:0] score_max(int unsigned digits);
    logic [ScoreW+3:0] p;
    p = (ScoreW + 4)'(1);
    for (int unsigned i = 0; i < digits; i++) begin
      p = (ScoreW + 4)'(p * 10);
    end
    return ScoreW'(p - (ScoreW + 4)'(1));
  endfunction

endpackage

### rtl/core/decimal_score_counter_display.sv
// ----------------------------------------------------------------------------
// Decimal score counter display
// Running score with add/set updates, clamped range and eight-digit display.
// ----------------------------------------------------------------------------
// Path: input queue, score update register, then the 4 conversion stages;
//   the last stage is the output.
// Throughput: one item per cycle while the result channel is not stalled; the
//   score add-and-clamp register closes the only loop, one update per cycle.
// Reset: score clears to zero, queue and pipeline empty at once.
// ----------------------------------------------------------------------------
module decimal_score_counter_display import dsc_pkg::*; #(
  parameter int unsigned Digits = DefaultDigits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     kind_i,
  input  logic signed [ValueW-1:0] value_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ScoreW-1:0]        score_now_o,
  output logic [DigitW-1:0]        digit_pos0_o,
  output logic [DigitW-1:0]        digit_pos1_o,
  output logic [DigitW-1:0]        digit_pos2_o,
  output logic [DigitW-1:0]        digit_pos3_o,
  output logic [DigitW-1:0]        digit_pos4_o,
  output logic [DigitW-1:0]        digit_pos5_o,
  output logic [DigitW-1:0]        digit_pos6_o,
  output logic [DigitW-1:0]        digit_pos7_o,
  output logic [Positions-1:0]     visible_mask_o
);

  // queue to score update
  logic  item_valid;
  item_t item;
  logic  item_pop;

  // score update to conversion pipeline
  logic              score_valid;
  logic [ScoreW-1:0] score;
  logic              score_take;

  logic [Positions-1:0][DigitW-1:0] digits;

  // Front end: accept a transfer, tag it as add or set, queue it. The stall
  // toward the source comes straight from the queue fill count.
  dsc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .in_stall_o   (in_stall_o),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  // Back end, part one: update and clamp the running score. Pop only when
  // the score register is free or being drained this cycle.
  dsc_score #(
    .Digits (Digits)
  ) u_score (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_pop_o    (item_pop),
    .score_valid_o (score_valid),
    .score_o       (score),
    .score_take_i  (score_take)
  );

  // Back end, part two: binary to decimal conversion; each full stage holds when
  // the stage after it is full and stalled.
  dsc_bcd_pipe #(
    .Digits (Digits)
  ) u_bcd_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (score_valid),
    .in_score_i   (score),
    .in_ready_o   (score_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_score_o  (score_now_o),
    .out_digits_o (digits),
    .out_mask_o   (visible_mask_o)
  );

  // position 0 is the most significant digit
  assign digit_pos0_o = digits[0];
  assign digit_pos1_o = digits[1];
  assign digit_pos2_o = digits[2];
  assign digit_pos3_o = digits[3];
  assign digit_pos4_o = digits[4];
  assign digit_pos5_o = digits[5];
  assign digit_pos6_o = digits[6];
  assign digit_pos7_o = digits[7];

endmodule

### rtl/core/dsc_front.sv
// ----------------------------------------------------------------------------
// Score counter front end
// Accept input transfers, classify them and hold them in a short queue.
// ----------------------------------------------------------------------------
module dsc_front import dsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     kind_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     in_stall_o,
  output logic                     item_valid_o,
  output item_t                    item_o,
  input  logic                     item_pop_i
);

  item_t                ent_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 full, push;
  item_t                new_item;

  assign full         = (cnt_q == QueueCntW'(QueueDepth));
  assign push         = in_valid_i && !full;
  assign in_stall_o   = full;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = ent_q[rd_ptr_q];

  always_comb begin
    new_item.op    = kind_i ? OP_SET : OP_ADD;
    new_item.value = value_i;
  end

  always_comb begin
    unique case ({push, item_pop_i})
      2'b10:   cnt_d = cnt_q + QueueCntW'(1);
      2'b01:   cnt_d = cnt_q - QueueCntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (item_pop_i) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= new_item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("queue fill count beyond depth");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !item_pop_i) |=> (cnt_q == $past(cnt_q) + QueueCntW'(1)))
    else $error("queue fill count missed a push");

endmodule

### rtl/core/dsc_score.sv
// ----------------------------------------------------------------------------
// Score counter update stage
// Apply an add or set to the running score and clamp it to the display range.
// ----------------------------------------------------------------------------
module dsc_score import dsc_pkg::*; #(
  parameter int unsigned Digits = DefaultDigits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  item_t             item_i,
  output logic              item_pop_o,
  output logic              score_valid_o,
  output logic [ScoreW-1:0] score_o,
  input  logic              score_take_i
);

  localparam logic [ScoreW-1:0] ScoreMax = score_max(Digits);

  logic [ScoreW-1:0]       score_q, score_d;
  logic                    vld_q;
  logic signed [ScoreW+1:0] sum;

  assign item_pop_o    = item_valid_i && (!vld_q || score_take_i);
  assign score_valid_o = vld_q;
  assign score_o       = score_q;

  always_comb begin
    unique case (item_i.op)
      OP_SET:  sum = $signed({item_i.value[ValueW-1], item_i.value});
      OP_ADD:  sum = $signed({2'b00, score_q})
                   + $signed({item_i.value[ValueW-1], item_i.value});
      default: sum = $signed({2'b00, score_q});
    endcase
    // floor at zero, saturate at the largest displayable score
    if (sum[ScoreW+1]) begin
      score_d = '0;
    end else if (sum > $signed({2'b00, ScoreMax})) begin
      score_d = ScoreMax;
    end else begin
      score_d = sum[ScoreW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q <= '0;
      vld_q   <= 1'b0;
    end else if (item_pop_o) begin
      score_q <= score_d;
      vld_q   <= 1'b1;
    end else if (score_take_i) begin
      vld_q   <= 1'b0;
    end
  end

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    score_q <= ScoreMax)
    else $error("score beyond display range");

endmodule

### rtl/core/dsc_bcd_pipe.sv
// ----------------------------------------------------------------------------
// Score counter decimal conversion pipeline
// Shift-and-add-3 conversion spread over stages, then leading zero blanking.
// ----------------------------------------------------------------------------
module dsc_bcd_pipe import dsc_pkg::*; #(
  parameter int unsigned Digits = DefaultDigits
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [ScoreW-1:0]                in_score_i,
  output logic                             in_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [ScoreW-1:0]                out_score_o,
  output logic [Positions-1:0][DigitW-1:0] out_digits_o,
  output logic [Positions-1:0]             out_mask_o
);

  localparam int unsigned BcdW = DigitW * Digits;
  localparam int unsigned Last = ConvStages - 1;

  logic [ConvStages-1:0] vld_q;
  logic [ConvStages:0]   rdy;
  logic [BcdW-1:0]       bcd_q   [ConvStages];
  logic [ScoreW-1:0]     bin_q   [ConvStages];
  logic [ScoreW-1:0]     score_q [ConvStages];

  assign rdy[ConvStages] = !out_stall_i;
  assign in_ready_o      = rdy[0];

  for (genvar s = 0; s < ConvStages; s++) begin : g_stage
    localparam int unsigned Lo    = s * StepsPerStage;
    localparam int unsigned Steps =
      (ScoreW - Lo < StepsPerStage) ? (ScoreW - Lo) : StepsPerStage;

    logic              src_vld;
    logic [BcdW-1:0]   src_bcd, bcd;
    logic [ScoreW-1:0] src_bin, src_score, bin;

    if (s == 0) begin : g_src_in
      assign src_vld   = in_valid_i;
      assign src_bcd   = '0;
      assign src_bin   = in_score_i;
      assign src_score = in_score_i;
    end else begin : g_src_prev
      assign src_vld   = vld_q[s-1];
      assign src_bcd   = bcd_q[s-1];
      assign src_bin   = bin_q[s-1];
      assign src_score = score_q[s-1];
    end

    assign rdy[s] = !vld_q[s] || rdy[s+1];

    always_comb begin
      bcd = src_bcd;
      bin = src_bin;
      for (int unsigned j = 0; j < Steps; j++) begin
        for (int unsigned k = 0; k < Digits; k++) begin
          if (bcd[k*DigitW +: DigitW] >= DigitW'(5)) begin
            bcd[k*DigitW +: DigitW] = bcd[k*DigitW +: DigitW] + DigitW'(3);
          end
        end
        {bcd, bin} = {bcd[BcdW-2:0], bin, 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        vld_q[s] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && src_vld) begin
        bcd_q[s]   <= bcd;
        bin_q[s]   <= bin;
        score_q[s] <= src_score;
      end
    end
  end

  // place digits, units at the last position; unused upper positions read zero
  for (genvar p = 0; p < Positions; p++) begin : g_pos
    if (Positions - 1 - p < Digits) begin : g_used
      assign out_digits_o[p] = bcd_q[Last][(Positions-1-p)*DigitW +: DigitW];
    end else begin : g_unused
      assign out_digits_o[p] = '0;
    end
  end

  // show from the first nonzero digit down; the units digit always shows
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int unsigned p = 0; p < Positions; p++) begin
      seen          = seen || (out_digits_o[p] != '0);
      out_mask_o[p] = seen;
    end
    out_mask_o[Positions-1] = 1'b1;
  end

  assign out_valid_o = vld_q[Last];
  assign out_score_o = score_q[Last];

  logic digits_ok;
  always_comb begin
    digits_ok = 1'b1;
    for (int unsigned k = 0; k < Digits; k++) begin
      if (bcd_q[Last][k*DigitW +: DigitW] > DigitW'(9)) begin
        digits_ok = 1'b0;
      end
    end
  end

  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> digits_ok)
    else $error("converted digit out of decimal range");

  // only the units digit shows exactly when the score is a single digit
  a_zero_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_score_o < ScoreW'(10)) ==
                     (out_mask_o == {1'b1, {(Positions-1){1'b0}}})))
    else $error("blanking mask disagrees with score");

endmodule
